@@ design/ocma_pkg.sv @@
// Shared constants and types for the offset-calibrated moving average.
`default_nettype none

package ocma_pkg;

  // Fixed widths of the channel words.
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned FILTERED_W = 16;

  // Default build settings for the top level.
  localparam int unsigned WINDOW_DEPTH_DEF        = 16;
  localparam int unsigned CALIBRATION_SAMPLES_DEF = 20;
  localparam int unsigned SAMPLE_BITS_DEF         = 16;

  // Control carried alongside each word as it moves down the pipe.
  typedef struct packed {
    logic valid;
    logic cal;
  } ocma_ctl_t;

endpackage

`default_nettype wire

@@ design/ocma_sample_if.sv @@
// Input channel: one raw converter sample per word.
`default_nettype none

interface ocma_sample_if
  import ocma_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

`default_nettype wire

@@ design/ocma_result_if.sv @@
// Output channel: filtered value and calibration flag per word.
`default_nettype none

interface ocma_result_if
  import ocma_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [FILTERED_W-1:0] filtered_value;
  logic                  calibrating;

  modport source (output valid, output filtered_value, output calibrating, input ready);
  modport sink   (input valid, input filtered_value, input calibrating, output ready);
endinterface

`default_nettype wire

@@ design/offset_calibrated_moving_average.sv @@
// Top level of the offset-calibrated moving average filter.
//
//  channel  dir  handshake     word fields
//  -------  ---  ------------  ------------------------------------------
//  in_i     in   valid/ready   sample[15:0] (low SAMPLE_BITS used)
//  out_o    out  valid/ready   filtered_value[15:0], calibrating
//
// One word per clock sustained while out_o takes words; an accepted word goes
// through ring RAM read at accept, then sum update, reciprocal multiply and
// offset subtract, and then lands in the output register.
// The ring RAM's registered read sets the first stage.
// Reset clears calibration, ring fill flag, running sum and all stage valids;
// no clearing pass is needed since unwritten ring entries read as zero.
// A stall at out_o holds every full stage; the input keeps accepting until
// the pipe in front of the stall is full.
`default_nettype none

module offset_calibrated_moving_average
  import ocma_pkg::*;
#(
  parameter int unsigned WINDOW_DEPTH        = WINDOW_DEPTH_DEF,
  parameter int unsigned CALIBRATION_SAMPLES = CALIBRATION_SAMPLES_DEF,
  parameter int unsigned SAMPLE_BITS         = SAMPLE_BITS_DEF
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  ocma_sample_if.sink  in_i,
  ocma_result_if.source out_o
);

  localparam int unsigned SUM_W = SAMPLE_BITS + $clog2(WINDOW_DEPTH);

  ocma_ctl_t              sum_ctl;
  logic                   sum_ready;
  logic [SUM_W-1:0]       sum;
  logic [SAMPLE_BITS-1:0] offset;
  logic                   in_ready;

  // Bits above SAMPLE_BITS are ignored.
  ocma_front #(
    .WINDOW_DEPTH        (WINDOW_DEPTH),
    .CALIBRATION_SAMPLES (CALIBRATION_SAMPLES),
    .SAMPLE_BITS         (SAMPLE_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_ready),
    .sample_i    (in_i.sample[SAMPLE_BITS-1:0]),
    .out_ctl_o   (sum_ctl),
    .out_ready_i (sum_ready),
    .sum_o       (sum),
    .offset_o    (offset)
  );

  assign in_i.ready = in_ready;

  ocma_back #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_ctl_i         (sum_ctl),
    .in_ready_o       (sum_ready),
    .sum_i            (sum),
    .offset_i         (offset),
    .out_valid_o      (out_o.valid),
    .out_ready_i      (out_o.ready),
    .filtered_value_o (out_o.filtered_value),
    .calibrating_o    (out_o.calibrating)
  );

endmodule

`default_nettype wire

@@ design/ocma_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module ocma_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read data holds while no read is issued.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

@@ design/ocma_front.sv @@
// Calibration, window ring and running sum: accept stage plus sum stage.
`default_nettype none

module ocma_front
  import ocma_pkg::*;
#(
  parameter int unsigned WINDOW_DEPTH        = WINDOW_DEPTH_DEF,
  parameter int unsigned CALIBRATION_SAMPLES = CALIBRATION_SAMPLES_DEF,
  parameter int unsigned SAMPLE_BITS         = SAMPLE_BITS_DEF
) (
  input  wire logic                                              clk_i,
  input  wire logic                                              rst_ni,
  input  wire logic                                              in_valid_i,
  output logic                                                   in_ready_o,
  input  wire logic [SAMPLE_BITS-1:0]                            sample_i,
  output ocma_ctl_t                                              out_ctl_o,
  input  wire logic                                              out_ready_i,
  output logic      [SAMPLE_BITS+$clog2(WINDOW_DEPTH)-1:0]       sum_o,
  output logic      [SAMPLE_BITS-1:0]                            offset_o
);

  localparam int unsigned SLOT_W = $clog2(WINDOW_DEPTH);
  localparam int unsigned SUM_W  = SAMPLE_BITS + SLOT_W;
  localparam int unsigned CNT_W  = $clog2(CALIBRATION_SAMPLES + 2);
  localparam logic [CNT_W-1:0]  CAL_LAST  = CNT_W'(CALIBRATION_SAMPLES);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW_DEPTH - 1);

  // Calibration state
  logic [CNT_W-1:0]       calib_count_q;
  logic [SAMPLE_BITS-1:0] offset_q;
  logic                   calibrating;

  // Ring state
  logic [SLOT_W-1:0] slot_q;
  logic              filled_q;
  logic [SUM_W-1:0]  sum_q;

  // Stage 1: waiting on RAM read data
  logic                   s1_valid_q;
  logic                   s1_cal_q;
  logic [SAMPLE_BITS-1:0] s1_sample_q;
  logic [SLOT_W-1:0]      s1_slot_q;
  logic                   s1_filled_q;

  // Stage 2: updated sum
  ocma_ctl_t        s2_ctl_q;
  logic [SUM_W-1:0] s2_sum_q;

  logic                   s2_free;
  logic                   s1_move;
  logic                   accept;
  logic [SAMPLE_BITS-1:0] ram_rdata;
  logic [SAMPLE_BITS-1:0] old_sample;
  logic [SUM_W-1:0]       sum_d;

  assign calibrating = (calib_count_q <= CAL_LAST);
  assign s2_free     = !s2_ctl_q.valid || out_ready_i;
  assign s1_move     = s1_valid_q && s2_free;
  assign in_ready_o  = !s1_valid_q || s2_free;
  assign accept      = in_valid_i && in_ready_o;

  // Entries not written since reset read as zero.
  assign old_sample = s1_filled_q ? ram_rdata : '0;
  assign sum_d      = sum_q - SUM_W'(old_sample) + SUM_W'(s1_sample_q);

  ocma_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (WINDOW_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (s1_move && !s1_cal_q),
    .waddr_i (s1_slot_q),
    .wdata_i (s1_sample_q),
    .re_i    (accept && !calibrating),
    .raddr_i (slot_q),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      calib_count_q <= '0;
      offset_q      <= '0;
      slot_q        <= '0;
      filled_q      <= 1'b0;
      sum_q         <= '0;
      s1_valid_q    <= 1'b0;
      s2_ctl_q      <= '0;
    end else begin
      if (accept) begin
        if (calibrating) begin
          calib_count_q <= calib_count_q + CNT_W'(1);
          if (calib_count_q == '0 || sample_i > offset_q) begin
            offset_q <= sample_i;
          end
        end else begin
          slot_q <= (slot_q == SLOT_LAST) ? '0 : slot_q + SLOT_W'(1);
          if (slot_q == SLOT_LAST) begin
            filled_q <= 1'b1;
          end
        end
      end

      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_move) begin
        s1_valid_q <= 1'b0;
      end

      if (s1_move && !s1_cal_q) begin
        sum_q <= sum_d;
      end

      if (s1_move) begin
        s2_ctl_q.valid <= 1'b1;
        s2_ctl_q.cal   <= s1_cal_q;
      end else if (out_ready_i) begin
        s2_ctl_q.valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_cal_q    <= calibrating;
      s1_sample_q <= sample_i;
      s1_slot_q   <= slot_q;
      s1_filled_q <= filled_q;
    end
    if (s1_move) begin
      s2_sum_q <= sum_d;
    end
  end

  assign out_ctl_o = s2_ctl_q;
  assign sum_o     = s2_sum_q;
  assign offset_o  = offset_q;

endmodule

`default_nettype wire

@@ design/ocma_back.sv @@
// Mean by reciprocal multiply, then offset removal with clamp at zero.
`default_nettype none

module ocma_back
  import ocma_pkg::*;
#(
  parameter int unsigned WINDOW_DEPTH = WINDOW_DEPTH_DEF,
  parameter int unsigned SAMPLE_BITS  = SAMPLE_BITS_DEF
) (
  input  wire logic                                        clk_i,
  input  wire logic                                        rst_ni,
  input  wire ocma_ctl_t                                   in_ctl_i,
  output logic                                             in_ready_o,
  input  wire logic [SAMPLE_BITS+$clog2(WINDOW_DEPTH)-1:0] sum_i,
  input  wire logic [SAMPLE_BITS-1:0]                      offset_i,
  output logic                                             out_valid_o,
  input  wire logic                                        out_ready_i,
  output logic      [FILTERED_W-1:0]                       filtered_value_o,
  output logic                                             calibrating_o
);

  localparam int unsigned SLOT_W      = $clog2(WINDOW_DEPTH);
  localparam int unsigned SUM_W       = SAMPLE_BITS + SLOT_W;
  localparam int unsigned RECIP_SHIFT = SUM_W + SLOT_W;
  localparam int unsigned RECIP_W     = SUM_W + 1;
  localparam int unsigned PROD_W      = SUM_W + RECIP_W;
  // ceil(2^(SUM_W+SLOT_W) / depth): exact floor division for any sum below 2^SUM_W
  localparam logic [63:0] RECIP_FULL =
    ((64'd1 << RECIP_SHIFT) + 64'(WINDOW_DEPTH) - 64'd1) / 64'(WINDOW_DEPTH);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_FULL);

  ocma_ctl_t              s3_ctl_q;
  logic [SAMPLE_BITS-1:0] s3_mean_q;
  logic                   out_valid_q;
  logic                   out_cal_q;
  logic [FILTERED_W-1:0]  out_value_q;

  logic                   s3_free;
  logic                   s3_move;
  logic [PROD_W-1:0]      product;
  logic [SAMPLE_BITS-1:0] mean_d;
  logic [SAMPLE_BITS-1:0] value_d;

  assign s3_free    = !out_valid_q || out_ready_i;
  assign s3_move    = s3_ctl_q.valid && s3_free;
  assign in_ready_o = !s3_ctl_q.valid || s3_free;

  assign product = PROD_W'(sum_i) * PROD_W'(RECIP);
  assign mean_d  = product[RECIP_SHIFT +: SAMPLE_BITS];

  assign value_d = (s3_mean_q >= offset_i) ? (s3_mean_q - offset_i) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_ctl_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ctl_i.valid && in_ready_o) begin
        s3_ctl_q <= in_ctl_i;
      end else if (s3_free) begin
        s3_ctl_q.valid <= 1'b0;
      end

      if (s3_move) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ctl_i.valid && in_ready_o) begin
      s3_mean_q <= mean_d;
    end
    if (s3_move) begin
      out_cal_q   <= s3_ctl_q.cal;
      // Held output is still zero while calibration runs.
      out_value_q <= s3_ctl_q.cal ? '0 : FILTERED_W'(value_d);
    end
  end

  assign out_valid_o      = out_valid_q;
  assign filtered_value_o = out_value_q;
  assign calibrating_o    = out_cal_q;

endmodule

`default_nettype wire

@@ tb/sv/ocma_filter_checker.sv @@
// Checker for the offset-calibrated moving average: predicts and compares each result word.
module ocma_filter_checker
  import ocma_pkg::*;
#(
  parameter int unsigned WINDOW_DEPTH        = WINDOW_DEPTH_DEF,
  parameter int unsigned CALIBRATION_SAMPLES = CALIBRATION_SAMPLES_DEF,
  parameter int unsigned SAMPLE_BITS         = SAMPLE_BITS_DEF
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  ocma_sample_if      sample_mon,
  ocma_result_if      result_mon,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  localparam int unsigned SLOT_W  = $clog2(WINDOW_DEPTH);
  localparam int unsigned SUM_W   = SAMPLE_BITS + SLOT_W;
  localparam int unsigned COUNT_W = $clog2(CALIBRATION_SAMPLES + 2);
  localparam logic [SAMPLE_W-1:0] SAMPLE_MASK = SAMPLE_W'((1 << SAMPLE_BITS) - 1);

  typedef struct packed {
    logic [FILTERED_W-1:0] filtered_value;
    logic                  calibrating;
  } filt_word_t;

  logic [SAMPLE_W-1:0]   window_ring [WINDOW_DEPTH];
  logic [SUM_W-1:0]      window_total;
  logic [SLOT_W-1:0]     oldest_slot;
  logic [COUNT_W-1:0]    calib_seen;
  logic [SAMPLE_W-1:0]   offset_est;
  logic [FILTERED_W-1:0] last_filtered;
  filt_word_t            filtered_q [$];

  // One sample in, one filtered word out; updates the shadow state.
  function automatic filt_word_t average_sample(input logic [SAMPLE_W-1:0] raw);
    logic [SAMPLE_W-1:0] s;
    logic [SUM_W-1:0]    mean;
    filt_word_t          w;
    s = raw & SAMPLE_MASK;
    w.calibrating = 1'b0;
    if (calib_seen <= CALIBRATION_SAMPLES) begin
      // first calibration word loads, later ones only raise
      if (calib_seen == '0 || s > offset_est) offset_est = s;
      calib_seen = calib_seen + 1'b1;
      w.calibrating = 1'b1;
    end else begin
      window_total = window_total - window_ring[oldest_slot] + s;
      window_ring[oldest_slot] = s;
      oldest_slot = (oldest_slot == SLOT_W'(WINDOW_DEPTH - 1)) ? '0 : oldest_slot + 1'b1;
      mean = SUM_W'(window_total / WINDOW_DEPTH);
      last_filtered = (mean >= offset_est) ? FILTERED_W'(mean - offset_est) : '0;
    end
    w.filtered_value = last_filtered;
    return w;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    filt_word_t want;
    if (!rst_ni) begin
      for (int k = 0; k < WINDOW_DEPTH; k++) window_ring[k] = '0;
      window_total  = '0;
      oldest_slot   = '0;
      calib_seen    = '0;
      offset_est    = '0;
      last_filtered = '0;
      filtered_q.delete();
    end else begin
      if (sample_mon.valid && sample_mon.ready)
        filtered_q.push_back(average_sample(sample_mon.sample));
      if (result_mon.valid && result_mon.ready) begin
        if (filtered_q.size() == 0) begin
          $error("unexpected word: filtered_value %0d calibrating %0b",
                 result_mon.filtered_value, result_mon.calibrating);
          fail_count_o++;
        end else begin
          want = filtered_q.pop_front();
          if (result_mon.filtered_value !== want.filtered_value) begin
            $error("filtered_value: expected %0d, actual %0d",
                   want.filtered_value, result_mon.filtered_value);
            fail_count_o++;
          end
          if (result_mon.calibrating !== want.calibrating) begin
            $error("calibrating: expected %0b, actual %0b",
                   want.calibrating, result_mon.calibrating);
            fail_count_o++;
          end
        end
      end
    end
    pending_o = filtered_q.size();
  end

endmodule

@@ tb/sv/offset_calibrated_moving_average_tb.sv @@
// Testbench top: drives sample words and result backpressure, gives the verdict.
module offset_calibrated_moving_average_tb;
  import ocma_pkg::*;

  localparam int unsigned CYCLE_LIMIT      = 200000;
  localparam int unsigned DRAIN_CYCLES     = 24;    // pipe is four deep, plenty of margin
  localparam int unsigned RANDOM_PER_PHASE = 270;
  localparam int unsigned MAX_GAP          = 200;
  // Calibration words never exceed this, so it is the offset for the whole run.
  localparam int unsigned OFFSET_LEVEL     = 4000;

  // Which side inserts bubbles in the current phase.
  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SOURCE,
    IDLE_SINK,
    IDLE_BOTH
  } idle_mode_e;

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;
  idle_mode_e  idle_mode = IDLE_NONE;
  int unsigned cycle_count = 0;
  int unsigned fail_count;
  int unsigned pending;
  int          drift_level = 8000;
  int unsigned burst_left = 0;
  int unsigned burst_value = 0;

  ocma_sample_if sample_ch ();
  ocma_result_if result_ch ();

  offset_calibrated_moving_average #(
    .WINDOW_DEPTH        (WINDOW_DEPTH_DEF),
    .CALIBRATION_SAMPLES (CALIBRATION_SAMPLES_DEF),
    .SAMPLE_BITS         (SAMPLE_BITS_DEF)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (sample_ch),
    .out_o  (result_ch)
  );

  ocma_filter_checker #(
    .WINDOW_DEPTH        (WINDOW_DEPTH_DEF),
    .CALIBRATION_SAMPLES (CALIBRATION_SAMPLES_DEF),
    .SAMPLE_BITS         (SAMPLE_BITS_DEF)
  ) filter_chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .sample_mon   (sample_ch),
    .result_mon   (result_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Run guard: a hung handshake ends here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Percent of cycles each side sits out in the current phase.
  function automatic int unsigned source_idle_pct();
    return (idle_mode == IDLE_SOURCE) ? 78 : (idle_mode == IDLE_BOTH) ? 14 : 0;
  endfunction

  function automatic int unsigned sink_idle_pct();
    return (idle_mode == IDLE_SINK) ? 78 : (idle_mode == IDLE_BOTH) ? 14 : 0;
  endfunction

  // Receiver backpressure: redrawn every cycle at the falling edge.
  always @(negedge clk_i) begin
    result_ch.ready <= !($urandom_range(99) < sink_idle_pct());
  end

  // Called at a falling edge; returns at the falling edge after the word is taken.
  // valid is left high, so back-to-back words need no extra assignment.
  task automatic send_sample(input logic [SAMPLE_W-1:0] value);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(99) < source_idle_pct() && gap < MAX_GAP) gap++;
    if (gap > 0) begin
      sample_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    sample_ch.valid  <= 1'b1;
    sample_ch.sample <= value;
    @(posedge clk_i);
    while (!sample_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Drop valid and hold off until every predicted word has come back.
  task automatic drain_pipe();
    sample_ch.valid <= 1'b0;
    wait (pending == 0);
    @(negedge clk_i);
  endtask

  // Mostly sustained levels and bursts so the window fills with coherent data;
  // the rest is uniform noise, values near the offset and the full-scale extremes.
  function automatic logic [SAMPLE_W-1:0] random_sample();
    int          v;
    int unsigned pick;
    if (burst_left > 0) begin
      burst_left--;
      return SAMPLE_W'(burst_value);
    end
    pick = $urandom_range(99);
    if (pick < 4) begin
      // full window of one value: top scale, zero, or at or just above the offset
      burst_left = $urandom_range(40, 16);
      case ($urandom_range(3))
        0:       burst_value = 16'hFFFF;
        1:       burst_value = 0;
        2:       burst_value = OFFSET_LEVEL;
        default: burst_value = OFFSET_LEVEL + 1;
      endcase
      return SAMPLE_W'(burst_value);
    end
    if (pick < 30) return SAMPLE_W'($urandom_range(65535));
    if (pick < 40) return ($urandom_range(1)) ? 16'hFFFF : 16'h0000;
    if (pick < 55) begin
      // hover around the offset so the clamp flips back and forth
      v = int'(OFFSET_LEVEL) + int'($urandom_range(800)) - 400;
      return SAMPLE_W'(v);
    end
    if ($urandom_range(31) == 0) drift_level = $urandom_range(65535);
    v = drift_level + int'($urandom_range(3000)) - 1500;
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return SAMPLE_W'(v);
  endfunction

  initial begin
    idle_mode_e phase_mode;
    sample_ch.valid  = 1'b0;
    sample_ch.sample = '0;
    result_ch.ready  = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Calibration: first word loads the offset even though later ones are smaller,
    // a smaller word must not lower it, a larger one raises it, an equal one holds.
    send_sample(16'd3000);
    send_sample(16'd100);
    send_sample(16'd0);
    send_sample(16'(OFFSET_LEVEL));
    send_sample(16'(OFFSET_LEVEL - 1));
    send_sample(16'(OFFSET_LEVEL));
    repeat (CALIBRATION_SAMPLES_DEF + 1 - 6)
      send_sample(16'($urandom_range(OFFSET_LEVEL)));

    // Window phase, ring still partly cleared: mean counts empty slots as zero.
    send_sample(16'hFFFF);
    send_sample(16'hFFFF);
    send_sample(16'hFFFF);
    send_sample(16'hFFFF);
    send_sample(16'hAAAA);
    send_sample(16'h5555);
    send_sample(16'h0000);
    send_sample(16'h0001);
    send_sample(16'h8000);

    // Let the pipe empty completely once before the random part.
    drain_pipe();

    for (int p = 0; p < 4; p++) begin
      phase_mode = idle_mode_e'(p);
      idle_mode = phase_mode;
      repeat (RANDOM_PER_PHASE) send_sample(random_sample());
      drain_pipe();
    end

    idle_mode = IDLE_NONE;
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/ocma_pkg.sv
design/ocma_sample_if.sv
design/ocma_result_if.sv
design/ocma_ram.sv
design/ocma_front.sv
design/ocma_back.sv
design/offset_calibrated_moving_average.sv
tb/sv/ocma_filter_checker.sv
tb/sv/offset_calibrated_moving_average_tb.sv
